// ===== rtl/adsr_pkg.sv =====
// Shared types, codes and constants of the ADSR envelope generator.
package adsr_pkg;

  localparam int LEN_W   = 24;
  localparam int LEVEL_W = 16;
  localparam int OP_W    = 2;
  localparam int STAGE_W = 2;
  localparam int APB_AW  = 5;
  localparam int APB_DW  = 32;
  localparam int REG_IDX_W = 3;

  localparam logic [LEVEL_W-1:0] LEVEL_ONE = 16'd32768;
  localparam logic [LEVEL_W-1:0] EPS_LEVEL = 16'd3;

  localparam logic [OP_W-1:0] OP_NOTE_ON  = 2'd1;
  localparam logic [OP_W-1:0] OP_NOTE_OFF = 2'd2;

  localparam logic [STAGE_W-1:0] STAGE_ATTACK  = 2'd0;
  localparam logic [STAGE_W-1:0] STAGE_DECAY   = 2'd1;
  localparam logic [STAGE_W-1:0] STAGE_SUSTAIN = 2'd2;
  localparam logic [STAGE_W-1:0] STAGE_RELEASE = 2'd3;

  localparam logic [REG_IDX_W-1:0] REG_ATTACK  = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_DECAY   = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_RELEASE = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_PEAK    = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_SUSTAIN = 3'd4;

  localparam logic [LEN_W-1:0]   RST_ATTACK  = 24'd882;
  localparam logic [LEN_W-1:0]   RST_DECAY   = 24'd441;
  localparam logic [LEN_W-1:0]   RST_RELEASE = 24'd1764;
  localparam logic [LEVEL_W-1:0] RST_PEAK    = 16'd32768;
  localparam logic [LEVEL_W-1:0] RST_SUSTAIN = 16'd26214;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CLASSIFY,
    ST_DIVIDE,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic [LEN_W-1:0]   attack_length;
    logic [LEN_W-1:0]   decay_length;
    logic [LEN_W-1:0]   release_length;
    logic [LEVEL_W-1:0] peak_level;
    logic [LEVEL_W-1:0] sustain_level;
  } cfg_regs_t;

  typedef struct packed {
    logic               start;
    logic [LEVEL_W-1:0] level;
    logic [LEN_W-1:0]   num;
    logic [LEN_W-1:0]   den;
  } md_req_t;

  typedef struct packed {
    logic               busy;
    logic               done;
    logic [LEVEL_W-1:0] quot;
  } md_rsp_t;

endpackage

// ===== rtl/adsr_cfg.sv =====
// APB-style configuration register file of the ADSR envelope generator.
module adsr_cfg
  import adsr_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output cfg_regs_t         regs
);

  cfg_regs_t              regs_r;
  cfg_regs_t              regs_nxt;
  logic [REG_IDX_W-1:0]   idx;
  logic                   wr_en;

  assign idx   = paddr[APB_AW-1:2];
  assign wr_en = psel & penable & pwrite;
  assign regs  = regs_r;

  always_comb begin
    regs_nxt = regs_r;
    if (wr_en) begin
      case (idx)
        REG_ATTACK:  regs_nxt.attack_length  = pwdata[LEN_W-1:0];
        REG_DECAY:   regs_nxt.decay_length   = pwdata[LEN_W-1:0];
        REG_RELEASE: regs_nxt.release_length = pwdata[LEN_W-1:0];
        REG_PEAK:    regs_nxt.peak_level     = pwdata[LEVEL_W-1:0];
        REG_SUSTAIN: regs_nxt.sustain_level  = pwdata[LEVEL_W-1:0];
        default:     regs_nxt = regs_r;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_ATTACK:  prdata = APB_DW'(regs_r.attack_length);
      REG_DECAY:   prdata = APB_DW'(regs_r.decay_length);
      REG_RELEASE: prdata = APB_DW'(regs_r.release_length);
      REG_PEAK:    prdata = APB_DW'(regs_r.peak_level);
      REG_SUSTAIN: prdata = APB_DW'(regs_r.sustain_level);
      default:     prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.attack_length  <= RST_ATTACK;
      regs_r.decay_length   <= RST_DECAY;
      regs_r.release_length <= RST_RELEASE;
      regs_r.peak_level     <= RST_PEAK;
      regs_r.sustain_level  <= RST_SUSTAIN;
    end else begin
      regs_r <= regs_nxt;
    end
  end

endmodule

// ===== rtl/adsr_muldiv.sv =====
// Bit-serial unit for floor(level * num / den): shift-add multiply, then restoring divide.
module adsr_muldiv
  import adsr_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  md_req_t req,
  output md_rsp_t rsp
);

  localparam int CNT_W = $clog2(LEVEL_W);

  logic [LEN_W-1:0]   hi_r, hi_nxt;
  logic [LEVEL_W-1:0] lo_r, lo_nxt;
  logic [LEN_W-1:0]   num_r, num_nxt;
  logic [LEN_W-1:0]   den_r, den_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               div_phase_r, div_phase_nxt;
  logic               busy_r, busy_nxt;
  logic               done_r, done_nxt;

  logic [LEN_W:0]     mul_sum;
  logic [LEN_W:0]     rem_shift;
  logic [LEN_W:0]     rem_diff;
  logic               rem_ge;
  logic               last_step;

  assign mul_sum   = {1'b0, hi_r} + (lo_r[0] ? {1'b0, num_r} : '0);
  assign rem_shift = {hi_r, lo_r[LEVEL_W-1]};
  assign rem_ge    = rem_shift >= {1'b0, den_r};
  assign rem_diff  = rem_shift - {1'b0, den_r};
  assign last_step = cnt_r == CNT_W'(LEVEL_W - 1);

  always_comb begin
    hi_nxt        = hi_r;
    lo_nxt        = lo_r;
    num_nxt       = num_r;
    den_nxt       = den_r;
    cnt_nxt       = cnt_r;
    div_phase_nxt = div_phase_r;
    busy_nxt      = busy_r;
    done_nxt      = 1'b0;
    if (req.start && !busy_r) begin
      hi_nxt        = '0;
      lo_nxt        = req.level;
      num_nxt       = req.num;
      den_nxt       = req.den;
      cnt_nxt       = '0;
      div_phase_nxt = 1'b0;
      busy_nxt      = 1'b1;
    end else if (busy_r) begin
      cnt_nxt = cnt_r + CNT_W'(1);
      if (!div_phase_r) begin
        hi_nxt = mul_sum[LEN_W:1];
        lo_nxt = {mul_sum[0], lo_r[LEVEL_W-1:1]};
        if (last_step) begin
          div_phase_nxt = 1'b1;
          cnt_nxt       = '0;
        end
      end else begin
        hi_nxt = rem_ge ? rem_diff[LEN_W-1:0] : rem_shift[LEN_W-1:0];
        lo_nxt = {lo_r[LEVEL_W-2:0], rem_ge};
        if (last_step) begin
          busy_nxt = 1'b0;
          done_nxt = 1'b1;
          cnt_nxt  = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      done_r      <= 1'b0;
      cnt_r       <= '0;
      div_phase_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      done_r      <= done_nxt;
      cnt_r       <= cnt_nxt;
      div_phase_r <= div_phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hi_r  <= hi_nxt;
    lo_r  <= lo_nxt;
    num_r <= num_nxt;
    den_r <= den_nxt;
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rsp.quot = lo_r;

  a_rem_below_den: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && div_phase_r |-> hi_r < den_r)
    else $error("remainder not below divisor");

  a_done_ends_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r && $past(busy_r))
    else $error("done without a finished run");

endmodule

// ===== rtl/adsr_envelope_generator.sv =====
// Top level of the linear ADSR envelope generator: event state, stage decode, output register.
//
//  channel | ports                                     | direction | transfer when
//  input   | in_valid, in_stall, in_op, in_time_now    | in        | in_valid & !in_stall
//  result  | out_valid, out_stall, out_amplitude/stage | out       | out_valid & !out_stall
//  config  | cfg_psel/penable/pwrite/paddr/pwdata/...  | in        | psel & penable & pwrite
//
// The elapsed time is taken at the transfer edge; out_valid rises after stage decode, the
// serial multiply-divide unit (16 multiply steps, then 16 divide steps), its done flag and
// the load of the output register. The next item may transfer once the output is loaded;
// a sustain level or a finished release skips the unit. Reset (rst_n low, synchronous) closes
// the gate, clears both event times and reloads the registers. in_stall is high while an item
// is at work; a stalled result holds the final step.
module adsr_envelope_generator
  import adsr_pkg::*;
#(
  parameter int TIME_BITS = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [OP_W-1:0]    in_op,
  input  logic [31:0]        in_time_now,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [LEVEL_W-1:0] out_amplitude,
  output logic [STAGE_W-1:0] out_stage,
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [APB_AW-1:0]  cfg_paddr,
  input  logic [APB_DW-1:0]  cfg_pwdata,
  output logic [APB_DW-1:0]  cfg_prdata,
  output logic               cfg_pready
);

  localparam int TW = TIME_BITS;
  localparam int CW = (TIME_BITS > LEN_W + 1) ? TIME_BITS : LEN_W + 1;

  cfg_regs_t regs;
  md_req_t   md_req;
  md_rsp_t   md_rsp;

  state_t state_r, state_nxt;

  logic               gate_r, gate_nxt;
  logic [TW-1:0]      on_time_r, on_time_nxt;
  logic [TW-1:0]      off_time_r, off_time_nxt;
  logic [TW-1:0]      e_r, e_nxt;
  logic [LEVEL_W-1:0] base_r, base_nxt;
  logic               sub_r, sub_nxt;
  logic               use_q_r, use_q_nxt;
  logic [STAGE_W-1:0] stage_r, stage_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [LEVEL_W-1:0] out_amp_r, out_amp_nxt;
  logic [STAGE_W-1:0] out_stage_r, out_stage_nxt;

  logic               in_xfer;
  logic [63:0]        now64;
  logic [TW-1:0]      now_w;

  logic [LEN_W-1:0]   a_len, d_len, r_len;
  logic [LEVEL_W-1:0] peak, sus, lvl_diff;
  logic [LEN_W:0]     ad_sum;
  logic [CW-1:0]      e_x;
  logic               in_attack, in_decay, release_done;
  logic [LEN_W-1:0]   k_dec, n_rel;

  logic [LEVEL_W:0]   fin_sum;
  logic [LEVEL_W-1:0] fin_amp;

  assign cfg_pready = 1'b1;

  adsr_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .regs    (regs)
  );

  adsr_muldiv u_muldiv (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (md_req),
    .rsp   (md_rsp)
  );

  assign in_stall = state_r != ST_IDLE;
  assign in_xfer  = in_valid && !in_stall;
  assign now64    = 64'(in_time_now);
  assign now_w    = now64[TW-1:0];

  assign a_len = (regs.attack_length == '0) ? LEN_W'(1) : regs.attack_length;
  assign d_len = (regs.decay_length == '0) ? LEN_W'(1) : regs.decay_length;
  assign r_len = (regs.release_length == '0) ? LEN_W'(1) : regs.release_length;
  assign peak  = (regs.peak_level > LEVEL_ONE) ? LEVEL_ONE : regs.peak_level;
  assign sus   = (regs.sustain_level > LEVEL_ONE) ? LEVEL_ONE : regs.sustain_level;
  assign lvl_diff = (peak >= sus) ? (peak - sus) : (sus - peak);

  assign ad_sum       = {1'b0, a_len} + {1'b0, d_len};
  assign e_x          = CW'(e_r);
  assign in_attack    = e_x <= CW'(a_len);
  assign in_decay     = e_x <= CW'(ad_sum);
  assign release_done = e_x >= CW'(r_len);
  assign k_dec        = e_x[LEN_W-1:0] - a_len;
  assign n_rel        = r_len - e_x[LEN_W-1:0];

  assign fin_sum = !use_q_r ? {1'b0, base_r}
                 : sub_r    ? {1'b0, base_r} - {1'b0, md_rsp.quot}
                 :            {1'b0, base_r} + {1'b0, md_rsp.quot};
  assign fin_amp = (fin_sum[LEVEL_W-1:0] <= EPS_LEVEL) ? '0 : fin_sum[LEVEL_W-1:0];

  always_comb begin
    state_nxt     = state_r;
    gate_nxt      = gate_r;
    on_time_nxt   = on_time_r;
    off_time_nxt  = off_time_r;
    e_nxt         = e_r;
    base_nxt      = base_r;
    sub_nxt       = sub_r;
    use_q_nxt     = use_q_r;
    stage_nxt     = stage_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_amp_nxt   = out_amp_r;
    out_stage_nxt = out_stage_r;
    md_req.start  = 1'b0;
    md_req.level  = '0;
    md_req.num    = '0;
    md_req.den    = LEN_W'(1);
    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          case (in_op)
            OP_NOTE_ON: begin
              gate_nxt    = 1'b1;
              on_time_nxt = now_w;
              e_nxt       = '0;
            end
            OP_NOTE_OFF: begin
              gate_nxt     = 1'b0;
              off_time_nxt = now_w;
              e_nxt        = '0;
            end
            default: begin
              e_nxt = now_w - (gate_r ? on_time_r : off_time_r);
            end
          endcase
          state_nxt = ST_CLASSIFY;
        end
      end
      ST_CLASSIFY: begin
        sub_nxt   = 1'b0;
        use_q_nxt = 1'b1;
        base_nxt  = '0;
        if (gate_r) begin
          if (in_attack) begin
            stage_nxt    = STAGE_ATTACK;
            md_req.level = peak;
            md_req.num   = e_x[LEN_W-1:0];
            md_req.den   = a_len;
          end else if (in_decay) begin
            stage_nxt    = STAGE_DECAY;
            base_nxt     = peak;
            sub_nxt      = peak >= sus;
            md_req.level = lvl_diff;
            md_req.num   = k_dec;
            md_req.den   = d_len;
          end else begin
            stage_nxt = STAGE_SUSTAIN;
            base_nxt  = sus;
            use_q_nxt = 1'b0;
          end
        end else begin
          stage_nxt = STAGE_RELEASE;
          if (release_done) begin
            use_q_nxt = 1'b0;
          end else begin
            md_req.level = sus;
            md_req.num   = n_rel;
            md_req.den   = r_len;
          end
        end
        md_req.start = use_q_nxt;
        state_nxt    = use_q_nxt ? ST_DIVIDE : ST_FINISH;
      end
      ST_DIVIDE: begin
        if (md_rsp.done) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_amp_nxt   = fin_amp;
          out_stage_nxt = stage_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      gate_r      <= 1'b0;
      on_time_r   <= '0;
      off_time_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      gate_r      <= gate_nxt;
      on_time_r   <= on_time_nxt;
      off_time_r  <= off_time_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    e_r         <= e_nxt;
    base_r      <= base_nxt;
    sub_r       <= sub_nxt;
    use_q_r     <= use_q_nxt;
    stage_r     <= stage_nxt;
    out_amp_r   <= out_amp_nxt;
    out_stage_r <= out_stage_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_amplitude = out_amp_r;
  assign out_stage     = out_stage_r;

  a_xfer_to_classify: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> state_r == ST_CLASSIFY)
    else $error("accepted item did not reach stage decode");

  a_amp_not_small: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_amp_r == '0 || out_amp_r > EPS_LEVEL)
    else $error("small level not forced to zero");

  a_amp_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_amp_r <= LEVEL_ONE)
    else $error("amplitude above one");

  a_divide_busy: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DIVIDE && !md_rsp.done |-> md_rsp.busy)
    else $error("waiting on an idle divide unit");

endmodule
